### src/thermostat_equilibration_supervisor_top_macros.svh
// assertion macros for the thermostat equilibration supervisor checker
// no dependencies; included by the checker file only
`ifndef THERMOSTAT_EQUILIBRATION_SUPERVISOR_TOP_MACROS_SVH
`define THERMOSTAT_EQUILIBRATION_SUPERVISOR_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define TES_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tes_pkg.sv
// shared types, constants and register map of the equilibration supervisor
// no dependencies
package tes_pkg;

	localparam int WINDOW_DEPTH_DEFAULT = 64;
	localparam int TEMP_W     = 32;
	localparam int INTERVAL_W = 16;
	localparam int SIZE_W     = 7;
	localparam int TOL_W      = 16;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;
	localparam int OUT_W      = 72;
	localparam int PROD_W     = TOL_W + TEMP_W;

	// register indexes (paddr[4:2])
	localparam logic [2:0] REG_WIN_SIZE        = 3'd0;
	localparam logic [2:0] REG_SAMPLE_EVERY    = 3'd1;
	localparam logic [2:0] REG_ASSESS_INTERVAL = 3'd2;
	localparam logic [2:0] REG_STEADY_TIME     = 3'd3;
	localparam logic [2:0] REG_TIMEOUT         = 3'd4;
	localparam logic [2:0] REG_TOLERANCE       = 3'd5;
	localparam logic [2:0] REG_TARGET          = 3'd6;

	// reset values
	localparam logic [SIZE_W-1:0]     RST_WIN_SIZE        = 7'd16;
	localparam logic [INTERVAL_W-1:0] RST_SAMPLE_EVERY    = 16'd1;
	localparam logic [INTERVAL_W-1:0] RST_ASSESS_INTERVAL = 16'd10;
	localparam logic [TEMP_W-1:0]     RST_STEADY_TIME     = 32'd100;
	localparam logic [TEMP_W-1:0]     RST_TIMEOUT         = 32'd10000;
	localparam logic [TOL_W-1:0]      RST_TOLERANCE       = 16'd3277;
	localparam logic [TEMP_W-1:0]     RST_TARGET          = 32'd65536;

	typedef struct packed {
		logic [SIZE_W-1:0]     win_size;
		logic [INTERVAL_W-1:0] sample_every;
		logic [INTERVAL_W-1:0] assess_every;
		logic [TEMP_W-1:0]     steady_span;
		logic [TEMP_W-1:0]     timeout;
		logic [TOL_W-1:0]      tolerance;
		logic [TEMP_W-1:0]     target_temperature;
	} cfg_t;

	typedef enum logic [1:0] {
		DIV_SI,
		DIV_AI,
		DIV_MEAN
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT_SI,
		ST_WAIT_AI,
		ST_SWEEP,
		ST_WAIT_MEAN,
		ST_MULT,
		ST_CHECK,
		ST_DECIDE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     ring_write;
		logic     take_ai;
		logic     sweep_init;
		logic     sweep_run;
		logic     mean_load;
		logic     mult;
		logic     check;
		logic     decide;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic div_busy;
		logic sweep_done;
		logic win_empty;
		logic out_free;
	} sts_t;

endpackage

### src/tes_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module tes_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/tes_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies
module tes_div #(
	parameter int DW = 39,
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder
);

	localparam int CNTW = $clog2(DW + 1);

	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   dq_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   dvs_q;
	logic [VW:0]     rem_sh;
	logic [VW:0]     rem_sub;
	logic            ge;

	assign rem_sh  = {rem_q, dq_q[DW-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign ge      = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNTW'(DW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			dq_q  <= {dq_q[DW-2:0], ge};
			rem_q <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
		end
	end

	assign busy      = cnt_q != '0;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

### src/tes_ctrl.sv
// sequencer of one time step: modulo checks, window sweep, mean, test, result
// depends on tes_pkg
module tes_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_valid,
	output logic          s_ready,
	output tes_pkg::cmd_t cmd,
	input  tes_pkg::sts_t sts
);

	tes_pkg::state_t state_q;
	tes_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tes_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tes_pkg::ST_IDLE: begin
				if (s_valid) state_nx = tes_pkg::ST_START;
			end
			tes_pkg::ST_START: begin
				state_nx = sts.active ? tes_pkg::ST_WAIT_SI : tes_pkg::ST_SWEEP;
			end
			tes_pkg::ST_WAIT_SI: begin
				if (!sts.div_busy) state_nx = tes_pkg::ST_WAIT_AI;
			end
			tes_pkg::ST_WAIT_AI: begin
				if (!sts.div_busy) state_nx = tes_pkg::ST_SWEEP;
			end
			tes_pkg::ST_SWEEP: begin
				if (sts.sweep_done) begin
					if (!sts.win_empty) begin
						state_nx = tes_pkg::ST_WAIT_MEAN;
					end else begin
						state_nx = sts.active ? tes_pkg::ST_MULT : tes_pkg::ST_OUT;
					end
				end
			end
			tes_pkg::ST_WAIT_MEAN: begin
				if (!sts.div_busy) begin
					state_nx = sts.active ? tes_pkg::ST_MULT : tes_pkg::ST_OUT;
				end
			end
			tes_pkg::ST_MULT:   state_nx = tes_pkg::ST_CHECK;
			tes_pkg::ST_CHECK:  state_nx = tes_pkg::ST_DECIDE;
			tes_pkg::ST_DECIDE: state_nx = tes_pkg::ST_OUT;
			tes_pkg::ST_OUT: begin
				if (sts.out_free) state_nx = tes_pkg::ST_IDLE;
			end
			default: state_nx = tes_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.div_sel = tes_pkg::DIV_SI;
		s_ready     = 1'b0;
		unique case (state_q)
			tes_pkg::ST_IDLE: begin
				s_ready  = 1'b1;
				cmd.load = s_valid;
			end
			tes_pkg::ST_START: begin
				if (sts.active) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = tes_pkg::DIV_SI;
				end else begin
					cmd.sweep_init = 1'b1;
				end
			end
			tes_pkg::ST_WAIT_SI: begin
				cmd.div_sel = tes_pkg::DIV_AI;
				if (!sts.div_busy) begin
					cmd.ring_write = 1'b1;
					cmd.div_start  = 1'b1;
				end
			end
			tes_pkg::ST_WAIT_AI: begin
				if (!sts.div_busy) begin
					cmd.take_ai    = 1'b1;
					cmd.sweep_init = 1'b1;
				end
			end
			tes_pkg::ST_SWEEP: begin
				cmd.sweep_run = 1'b1;
				cmd.div_sel   = tes_pkg::DIV_MEAN;
				if (sts.sweep_done) begin
					if (sts.win_empty) cmd.mean_load = 1'b1;
					else cmd.div_start = 1'b1;
				end
			end
			tes_pkg::ST_WAIT_MEAN: begin
				if (!sts.div_busy) cmd.mean_load = 1'b1;
			end
			tes_pkg::ST_MULT:   cmd.mult   = 1'b1;
			tes_pkg::ST_CHECK:  cmd.check  = 1'b1;
			tes_pkg::ST_DECIDE: cmd.decide = 1'b1;
			tes_pkg::ST_OUT: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				s_ready = 1'b0;
			end
		endcase
	end

endmodule

### src/tes_dp.sv
// datapath: sample ring, run counters, shared divider, tolerance test, result register
// depends on tes_pkg, tes_ram, tes_div
module tes_dp #(
	parameter int WINDOW_DEPTH = tes_pkg::WINDOW_DEPTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tes_pkg::cmd_t             cmd,
	output tes_pkg::sts_t             sts,
	input  tes_pkg::cfg_t             cfg,
	input  logic [tes_pkg::TEMP_W-1:0] in_temp,
	input  logic                      in_new_run,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [tes_pkg::OUT_W-1:0] out_data
);

	localparam int PW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW   = $clog2(WINDOW_DEPTH + 1);
	localparam int TW   = tes_pkg::TEMP_W;
	localparam int SUMW = TW + CW;
	localparam int VW   = tes_pkg::INTERVAL_W;
	localparam int PADW = tes_pkg::OUT_W - 2 * TW - 3;
	localparam logic [PW-1:0] LAST_ADDR = PW'(WINDOW_DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C   = CW'(WINDOW_DEPTH);

	// run state
	logic                  act_q;
	logic [PW-1:0]         wp_q;
	logic [CW-1:0]         fill_q;
	logic [TW-1:0]         step_q;
	logic [TW-1:0]         last_adj_q;
	logic                  fin_q;
	// per-step working registers
	logic [TW-1:0]         temp_q;
	logic                  assess_q;
	logic [CW-1:0]         m_q;
	logic [CW-1:0]         k_q;
	logic [PW-1:0]         rd_addr_q;
	logic                  rd_v_s1;
	logic [SUMW-1:0]       sum_q;
	logic [TW-1:0]         mean_q;
	logic [tes_pkg::PROD_W-1:0] prod_q;
	logic                  rescale_q;
	logic                  done_q;
	logic                  failed_q;
	logic                  out_valid_q;
	logic [tes_pkg::OUT_W-1:0] out_data_q;

	logic [VW-1:0]   si_eff;
	logic [VW-1:0]   ai_eff;
	logic [CW-1:0]   n_eff;
	logic [CW-1:0]   m_now;
	logic [SUMW-1:0] div_a;
	logic [VW-1:0]   div_b;
	logic [SUMW-1:0] div_quot;
	logic [VW-1:0]   div_rem;
	logic            div_busy;
	logic            rem_zero;
	logic            ram_we;
	logic [TW-1:0]   ram_rdata;
	logic            issue;
	logic [TW-1:0]   diff;
	logic            hit;
	logic            assess_en;
	logic [TW-1:0]   elapsed;
	logic            reached;
	logic            expire;

	assign si_eff = (cfg.sample_every == '0) ? VW'(1) : cfg.sample_every;
	assign ai_eff = (cfg.assess_every == '0) ? VW'(1) : cfg.assess_every;

	// window length clamped to 1..depth
	always_comb begin
		if (cfg.win_size == '0) begin
			n_eff = CW'(1);
		end else if (32'(cfg.win_size) > 32'(WINDOW_DEPTH)) begin
			n_eff = DEPTH_C;
		end else begin
			n_eff = CW'(cfg.win_size);
		end
	end

	assign m_now = (fill_q < n_eff) ? fill_q : n_eff;

	always_comb begin
		case (cmd.div_sel)
			tes_pkg::DIV_SI: begin
				div_a = SUMW'(step_q);
				div_b = si_eff;
			end
			tes_pkg::DIV_AI: begin
				div_a = SUMW'(step_q);
				div_b = ai_eff;
			end
			tes_pkg::DIV_MEAN: begin
				div_a = sum_q;
				div_b = VW'(m_q);
			end
			default: begin
				div_a = SUMW'(step_q);
				div_b = VW'(1);
			end
		endcase
	end

	tes_div #(
		.DW(SUMW),
		.VW(VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.quotient (div_quot),
		.remainder(div_rem)
	);

	assign rem_zero = div_rem == '0;
	assign ram_we   = cmd.ring_write && rem_zero;

	tes_ram #(
		.WIDTH(TW),
		.DEPTH(WINDOW_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wp_q),
		.wdata(temp_q),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	assign issue = cmd.sweep_run && (k_q != m_q);

	// tolerance test: |mean - target| * 2^16 >= tolerance * target; with a zero target, any nonzero mean hits
	assign diff = (mean_q >= cfg.target_temperature) ? (mean_q - cfg.target_temperature)
		: (cfg.target_temperature - mean_q);
	assign hit = (cfg.target_temperature == '0) ? (mean_q != '0)
		: ({diff, 16'h0000} >= prod_q);
	assign assess_en = act_q && assess_q && (m_q != '0);

	assign elapsed = step_q - last_adj_q;
	assign reached = elapsed >= cfg.steady_span;
	assign expire  = ({1'b0, step_q} + 33'd1) >= {1'b0, cfg.timeout};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			wp_q        <= '0;
			fill_q      <= '0;
			step_q      <= '0;
			last_adj_q  <= '0;
			fin_q       <= 1'b0;
			k_q         <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (in_new_run) begin
					wp_q       <= '0;
					fill_q     <= '0;
					step_q     <= '0;
					last_adj_q <= '0;
					fin_q      <= 1'b0;
					act_q      <= 1'b1;
				end else begin
					act_q <= !fin_q;
				end
			end
			if (ram_we) begin
				wp_q <= (wp_q == LAST_ADDR) ? '0 : wp_q + 1'b1;
				if (fill_q != DEPTH_C) fill_q <= fill_q + 1'b1;
			end
			if (cmd.sweep_init) begin
				k_q     <= '0;
				rd_v_s1 <= 1'b0;
			end else if (cmd.sweep_run) begin
				rd_v_s1 <= issue;
				if (issue) k_q <= k_q + 1'b1;
			end
			if (cmd.check && assess_en && hit) begin
				last_adj_q <= step_q;
			end
			if (cmd.decide && (reached || expire)) begin
				fin_q <= 1'b1;
			end
			if (cmd.out_load && act_q) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			temp_q    <= in_temp;
			rescale_q <= 1'b0;
			done_q    <= 1'b0;
			failed_q  <= 1'b0;
		end
		if (cmd.take_ai) begin
			assess_q <= rem_zero;
		end
		if (cmd.sweep_init) begin
			m_q       <= m_now;
			sum_q     <= '0;
			rd_addr_q <= (wp_q == '0) ? LAST_ADDR : wp_q - 1'b1;
		end else if (cmd.sweep_run) begin
			if (issue) rd_addr_q <= (rd_addr_q == '0) ? LAST_ADDR : rd_addr_q - 1'b1;
			if (rd_v_s1) sum_q <= sum_q + SUMW'(ram_rdata);
		end
		if (cmd.mean_load) begin
			mean_q <= (m_q == '0) ? '0 : div_quot[TW-1:0];
		end
		if (cmd.mult) begin
			prod_q <= cfg.tolerance * cfg.target_temperature;
		end
		if (cmd.check) begin
			rescale_q <= assess_en && hit;
		end
		if (cmd.decide) begin
			done_q   <= reached;
			failed_q <= !reached && expire;
		end
		if (cmd.out_load) begin
			out_data_q <= {{PADW{1'b0}}, step_q, mean_q, failed_q, done_q, rescale_q};
		end
	end

	assign sts.active     = act_q;
	assign sts.div_busy   = div_busy;
	assign sts.sweep_done = (k_q == m_q) && !rd_v_s1;
	assign sts.win_empty  = m_q == '0;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### src/thermostat_equilibration_supervisor_top.sv
// top level of the thermostat equilibration supervisor: apb registers, sequencer, datapath
// depends on tes_pkg, tes_ctrl, tes_dp (and through it tes_div, tes_ram)
//
//  channel   direction  handshake              payload
//  s_*       in         s_tvalid / s_tready    s_tdata = temperature sample, s_tuser = new_run
//  m_*       out        m_tvalid / m_tready    m_tdata = rescale, done_res, failed, mean, step
//  apb       in         psel, penable, pready  paddr[4:2] = register index, pwdata, prdata
//
// active step: three passes of the shared bit-serial divider (sample interval, assess interval,
// mean) and the window sweep over m = window count; divider width DW = 32+ceil(log2(WINDOW_DEPTH+1))
// empty window: no mean division; finished run: no interval divisions
// reset clears the run counters, write pointer and finished flag; ring contents are not cleared
// a stalled m_tready only holds the sequencer in its output state; the next input transfer is
// taken the cycle after the result is registered
module thermostat_equilibration_supervisor_top #(
	parameter int WINDOW_DEPTH = tes_pkg::WINDOW_DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [tes_pkg::TEMP_W-1:0]  s_tdata,   // [31:0] temperature sample
	input  logic [0:0]                  s_tuser,   // [0] new_run
	// result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [tes_pkg::OUT_W-1:0]   m_tdata,   // [0] rescale, [1] done_res, [2] failed,
	                                               // [34:3] window_mean, [66:35] step_index
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tes_pkg::ADDR_W-1:0]  paddr,
	input  logic [tes_pkg::DATA_W-1:0]  pwdata,
	output logic [tes_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	tes_pkg::cfg_t cfg_q;
	tes_pkg::cmd_t cmd;
	tes_pkg::sts_t sts;
	logic          cfg_wr;
	logic [2:0]    reg_idx;

	// apb: zero wait states, write lands on the access cycle
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_size           <= tes_pkg::RST_WIN_SIZE;
			cfg_q.sample_every       <= tes_pkg::RST_SAMPLE_EVERY;
			cfg_q.assess_every       <= tes_pkg::RST_ASSESS_INTERVAL;
			cfg_q.steady_span        <= tes_pkg::RST_STEADY_TIME;
			cfg_q.timeout            <= tes_pkg::RST_TIMEOUT;
			cfg_q.tolerance          <= tes_pkg::RST_TOLERANCE;
			cfg_q.target_temperature <= tes_pkg::RST_TARGET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				tes_pkg::REG_WIN_SIZE:
					cfg_q.win_size <= pwdata[tes_pkg::SIZE_W-1:0];
				tes_pkg::REG_SAMPLE_EVERY:
					cfg_q.sample_every <= pwdata[tes_pkg::INTERVAL_W-1:0];
				tes_pkg::REG_ASSESS_INTERVAL:
					cfg_q.assess_every <= pwdata[tes_pkg::INTERVAL_W-1:0];
				tes_pkg::REG_STEADY_TIME:
					cfg_q.steady_span <= pwdata;
				tes_pkg::REG_TIMEOUT:
					cfg_q.timeout <= pwdata;
				tes_pkg::REG_TOLERANCE:
					cfg_q.tolerance <= pwdata[tes_pkg::TOL_W-1:0];
				tes_pkg::REG_TARGET:
					cfg_q.target_temperature <= pwdata;
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

	// read mux, unmapped indexes read as zero
	always_comb begin
		unique case (reg_idx)
			tes_pkg::REG_WIN_SIZE:        prdata = 32'(cfg_q.win_size);
			tes_pkg::REG_SAMPLE_EVERY:    prdata = 32'(cfg_q.sample_every);
			tes_pkg::REG_ASSESS_INTERVAL: prdata = 32'(cfg_q.assess_every);
			tes_pkg::REG_STEADY_TIME:     prdata = cfg_q.steady_span;
			tes_pkg::REG_TIMEOUT:         prdata = cfg_q.timeout;
			tes_pkg::REG_TOLERANCE:       prdata = 32'(cfg_q.tolerance);
			tes_pkg::REG_TARGET:          prdata = cfg_q.target_temperature;
			default:                      prdata = '0;
		endcase
	end

	// sequencer: one step at a time, accepts only from its idle state
	tes_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.s_valid(s_tvalid),
		.s_ready(s_tready),
		.cmd    (cmd),
		.sts    (sts)
	);

	// datapath: ring, counters, divider, tolerance test and result register
	tes_dp #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg       (cfg_q),
		.in_temp   (s_tdata),
		.in_new_run(s_tuser[0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

### src/tes_checker.sv
// port-level checks of the equilibration supervisor, bound to the top level
// depends on tes_pkg and thermostat_equilibration_supervisor_top_macros.svh
`include "thermostat_equilibration_supervisor_top_macros.svh"

module tes_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [tes_pkg::OUT_W-1:0] m_tdata
);

	// a stalled result holds
	`TES_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// done and failed never come together
	`TES_ASSERT_IMP(a_done_xor_fail, clk, arst_n, m_tvalid, !(m_tdata[1] && m_tdata[2]), "done and failed both set")

	// one step in flight: input closes right after a transfer
	`TES_ASSERT_NXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready, "input taken while a step is in flight")

endmodule

bind thermostat_equilibration_supervisor_top tes_checker u_tes_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
